// ===== sv/assert_macros.svh =====
// assertion macros shared by the cartridge bank controller rtl
// expects aclk and aresetn in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies expectation in the same cycle
`define CBC_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// condition implies expectation in the next cycle
`define CBC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/cbc_pkg.sv =====
// shared types and constants of the cartridge bank controller
// no dependencies
`default_nettype none

package cbc_pkg;

    // sizes
    localparam int RAM_BANKS_DEF = 4;
    localparam int BANK_BYTES    = 8192;
    localparam int OFF_W         = 13;
    localparam int BANK_IDX_W    = 4;
    localparam int ROM_BANK_W    = 7;
    localparam int ROM_ADDR_W    = 21;
    localparam int FIFO_DEPTH    = 4;

    // access kinds carried in s_tuser
    localparam logic [1:0] OP_ROM_RD = 2'd0;
    localparam logic [1:0] OP_REG_WR = 2'd1;
    localparam logic [1:0] OP_RAM_RD = 2'd2;
    localparam logic [1:0] OP_RAM_WR = 2'd3;

    // controller kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC2 = 2'd2;

    // register window codes (address bits 15:13)
    localparam logic [2:0] WIN_RAM_EN   = 3'd0;
    localparam logic [2:0] WIN_ROM_BANK = 3'd1;
    localparam logic [2:0] WIN_RAM_BANK = 3'd2;
    localparam logic [2:0] WIN_MODE     = 3'd3;

    // data masks
    localparam logic [4:0] ROM_BANK_MASK = 5'h1F;
    localparam logic [1:0] RAM_SEL_MASK  = 2'h3;
    localparam logic [7:0] ENABLE_BITS   = 8'h0A;
    localparam logic [4:0] BANK_ONE      = 5'h01;

    // one queued access, already resolved against the bank registers
    typedef struct packed {
        logic                  has_result;
        logic                  is_rom;
        logic                  ram_wr;
        logic                  ram_en;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [BANK_IDX_W-1:0] ram_bank;
        logic [OFF_W-1:0]      ram_offset;
        logic [7:0]            write_data;
    } cbc_entry_t;

endpackage

`default_nettype wire

// ===== sv/cbc_front.sv =====
// front end: accepts bus accesses, keeps the bank registers, resolves addresses
// depends on cbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cbc_front import cbc_pkg::*; #(
    parameter int RAM_BANKS = RAM_BANKS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_kind,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // op
    input  wire logic [23:0] s_tdata,   // address [15:0], write_data [23:16]
    input  wire logic        clear_busy,
    input  wire logic        q_full,
    output logic             push,
    output cbc_entry_t       push_entry
);

    logic [1:0]            kind_reg;
    logic                  ram_en_reg, ram_en_next;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [1:0]            ram_sel_reg, ram_sel_next;
    logic                  mode_reg, mode_next;

    logic                  accept;
    logic [15:0]           addr;
    logic [7:0]            wdata;
    logic [4:0]            bank5;
    logic [BANK_IDX_W-1:0] ram_bank;

    assign addr     = s_tdata[15:0];
    assign wdata    = s_tdata[23:16];
    assign s_tready = !clear_busy && !q_full;
    assign accept   = s_tvalid && s_tready;

    // ram bank select wrapped to the number of banks
    always_comb begin
        case (ram_sel_reg)
            2'd0:    ram_bank = BANK_IDX_W'(0 % RAM_BANKS);
            2'd1:    ram_bank = BANK_IDX_W'(1 % RAM_BANKS);
            2'd2:    ram_bank = BANK_IDX_W'(2 % RAM_BANKS);
            default: ram_bank = BANK_IDX_W'(3 % RAM_BANKS);
        endcase
    end

    // bank register updates on register writes
    always_comb begin
        ram_en_next   = ram_en_reg;
        rom_bank_next = rom_bank_reg;
        ram_sel_next  = ram_sel_reg;
        mode_next     = mode_reg;
        bank5         = wdata[4:0] & ROM_BANK_MASK;
        if (bank5 == 5'd0) begin
            bank5 = BANK_ONE;
        end
        if (accept && s_tuser == OP_REG_WR) begin
            if (kind_reg == KIND_MBC1) begin
                case (addr[15:13])
                    WIN_RAM_EN: begin
                        if (wdata == 8'd0) begin
                            ram_en_next = 1'b0;
                        end else if ((wdata & ENABLE_BITS) != 8'd0) begin
                            ram_en_next = 1'b1;
                        end
                    end
                    WIN_ROM_BANK: begin
                        rom_bank_next = mode_reg ? {ram_sel_reg, bank5} : {2'b00, bank5};
                    end
                    WIN_RAM_BANK: begin
                        ram_sel_next = wdata[1:0] & RAM_SEL_MASK;
                    end
                    WIN_MODE: begin
                        mode_next = wdata[0];
                    end
                    default: begin
                    end
                endcase
            end else if (kind_reg == KIND_MBC2) begin
                if (addr[15:13] == WIN_RAM_EN && !addr[8]) begin
                    ram_en_next = (wdata & ENABLE_BITS) != 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_NONE;
            ram_en_reg   <= 1'b0;
            rom_bank_reg <= ROM_BANK_W'(1);
            ram_sel_reg  <= 2'd0;
            mode_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                kind_reg <= cfg_kind;
            end
            ram_en_reg   <= ram_en_next;
            rom_bank_reg <= rom_bank_next;
            ram_sel_reg  <= ram_sel_next;
            mode_reg     <= mode_next;
        end
    end

    // classify the access and build the queue entry
    always_comb begin
        push_entry             = '0;
        push_entry.ram_bank    = ram_bank;
        push_entry.ram_offset  = addr[OFF_W-1:0];
        push_entry.write_data  = wdata;
        push_entry.ram_en      = ram_en_reg;
        push = 1'b0;
        case (s_tuser)
            OP_ROM_RD: begin
                push                   = accept;
                push_entry.has_result  = 1'b1;
                push_entry.is_rom      = 1'b1;
                push_entry.rom_address = (addr[15:14] == 2'b00) ?
                    {5'd0, addr} : {rom_bank_reg, addr[13:0]};
            end
            OP_RAM_RD: begin
                push                  = accept;
                push_entry.has_result = 1'b1;
            end
            OP_RAM_WR: begin
                push              = accept && ram_en_reg;
                push_entry.ram_wr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // the bank number low bits never read as zero
    `CBC_ASSERT_NOW(a_rom_bank_nz, 1'b1, rom_bank_reg[4:0] != 5'd0, "rom bank low bits zero")

endmodule

`default_nettype wire

// ===== sv/cbc_fifo.sv =====
// short queue of resolved accesses between front and back
// depends on cbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cbc_fifo import cbc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire cbc_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            q_valid,
    output cbc_entry_t      q_entry
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cbc_entry_t       slots_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == CNT_W'(FIFO_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_entry = slots_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `CBC_ASSERT_NOW(a_fifo_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "queue overflow")

endmodule

`default_nettype wire

// ===== sv/cbc_back.sv =====
// back end: cartridge ram, clearing pass after reset, result register
// depends on cbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cbc_back import cbc_pkg::*; #(
    parameter int RAM_BANKS = RAM_BANKS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire cbc_entry_t  q_entry,
    output logic             pop,
    output logic             clear_busy,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tuser,   // is_rom
    output logic [31:0]      m_tdata    // read_data [7:0], rom_address [28:8], zero [31:29]
);

    localparam int DEPTH  = RAM_BANKS * BANK_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]            ram_mem [DEPTH];
    logic [7:0]            rd_q;
    logic                  clear_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;

    logic                  s1_valid_reg;
    logic                  s1_is_rom_reg;
    logic                  s1_en_reg;
    logic [ROM_ADDR_W-1:0] s1_rom_reg;
    logic                  s1_adv;

    logic                  out_valid_reg;
    logic                  out_is_rom_reg;
    logic [7:0]            out_data_reg;
    logic [ROM_ADDR_W-1:0] out_rom_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [ADDR_W-1:0]     q_addr;
    logic [BANK_IDX_W+OFF_W-1:0] q_addr_full;

    assign clear_busy  = clear_reg;
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign pop         = q_valid && !clear_reg && (!s1_valid_reg || s1_adv);
    assign q_addr_full = {q_entry.ram_bank, q_entry.ram_offset};
    assign q_addr      = q_addr_full[ADDR_W-1:0];
    assign mem_we      = clear_reg || (pop && q_entry.ram_wr);
    assign mem_addr    = clear_reg ? clr_cnt_reg : q_addr;

    // clearing pass over the whole ram after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clear_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // ram with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ram_mem[mem_addr] <= clear_reg ? 8'd0 : q_entry.write_data;
        end
        if (pop) begin
            rd_q <= ram_mem[q_addr];
        end
    end

    // read stage: waits for the ram data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pop) begin
            s1_valid_reg <= q_entry.has_result;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_is_rom_reg <= q_entry.is_rom;
            s1_en_reg     <= q_entry.ram_en;
            s1_rom_reg    <= q_entry.rom_address;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_is_rom_reg <= s1_is_rom_reg;
            out_rom_reg    <= s1_is_rom_reg ? s1_rom_reg : '0;
            out_data_reg   <= (!s1_is_rom_reg && s1_en_reg) ? rd_q : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_is_rom_reg;
    assign m_tdata  = {3'b000, out_rom_reg, out_data_reg};

    `CBC_ASSERT_NOW(a_no_pop_clear, clear_reg, !pop, "queue popped during clearing pass")
    `CBC_ASSERT_NEXT(a_rd_hold, s1_valid_reg && !s1_adv, $stable(rd_q), "ram data lost while stalled")

endmodule

`default_nettype wire

// ===== sv/cartridge_bank_controller_unit.sv =====
// Cartridge bank controller (MBC1 style with MBC2 ram enable). Each input
// transfer is one bus access selected by s_tuser; rom and ram reads each
// return one result transfer, register writes and ram writes return none.
// One access is taken per clock whenever s_tready is high (queue not full, no
// clearing pass); a read result passes the queue slot, the registered ram read
// and the result register before m_tvalid offers it. After reset the ram is swept
// to zero one byte a cycle, RAM_BANKS * 8192 bytes (32768 by default), with
// s_tready low; the controller kind register on cfg_* may be written at any time.
// depends on cbc_pkg, cbc_front, cbc_fifo, cbc_back
`default_nettype none

module cartridge_bank_controller_unit import cbc_pkg::*; #(
    parameter int RAM_BANKS = RAM_BANKS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_tvalid,
    output logic             cfg_tready,
    input  wire logic [7:0]  cfg_tdata,  // controller_kind [1:0], zero [7:2]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,    // op
    input  wire logic [23:0] s_tdata,    // address [15:0], write_data [23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tuser,    // is_rom
    output logic [31:0]      m_tdata     // read_data [7:0], rom_address [28:8], zero [31:29]
);

    logic       push, pop, q_full, q_valid, clear_busy;
    cbc_entry_t push_entry, q_entry;

    assign cfg_tready = 1'b1;

    cbc_front #(.RAM_BANKS(RAM_BANKS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_tvalid),
        .cfg_kind   (cfg_tdata[1:0]),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cbc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    cbc_back #(.RAM_BANKS(RAM_BANKS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
